/* rtl/iopbm_pkg.sv */
package iopbm_pkg;

    // Field widths of the request and result items.
    localparam int START_W  = 16;
    localparam int LEN_W    = 17;
    localparam int STATUS_W = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int M_USED_W  = STATUS_W + 1 + LEN_W;

    // Bit positions of the request fields in s_tdata.
    localparam int S_START_LSB = 0;
    localparam int S_LEN_LSB   = START_W;
    localparam int S_EN_BIT    = START_W + LEN_W;

    // Request commands, carried on s_tuser.
    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_INVALID       = 2'd1;
    localparam status_t ST_NOT_PERMITTED = 2'd2;

endpackage

/* rtl/iopbm_ram.sv */
module iopbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/io_permission_bitmap_engine.sv */
// Channel   Direction  Content
// s_*       in         request item: tuser = cmd; tdata = start_req, length, enable
// m_*       out        result item: tdata = status, run_enable, run_length
// cfg_*     in         write_lock register, written when cfg_we is high
//
// After reset a clearing pass writes all ones into the map memory, one word a
// cycle; no item is accepted meanwhile.
// Refused, invalid and absent-map requests go from acceptance straight to the
// result stage, S_OUT, which loads their result.
// Other requests first find the start word in S_DIV, then walk the map words
// through the memory's registered read port in S_SCAN, one word a cycle, and
// last load the result in S_OUT.
// One item is worked on at a time; a result still waiting on m_tready holds the
// next item in its result stage.
module io_permission_bitmap_engine
    import iopbm_pkg::*;
#(
    parameter int PORT_COUNT = 65536,
    parameter int WORD_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request item.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // start_req[15:0], length[32:16], enable[33]
    input  logic                 s_tuser,   // cmd
    // Result item.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status[1:0], run_enable[2], run_length[19:3]
    // Lock register.
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);

    localparam int NUM_WORDS = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int DCNT_W    = 2;

    // Reciprocal of WORD_BITS, exact for every 16-bit start port.
    localparam int     DSH     = START_W + $clog2(WORD_BITS);
    localparam int     RCP_W   = START_W + 2;
    localparam int     PROD_W  = START_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << DSH) + longint'(WORD_BITS) - 1) /
                                 longint'(WORD_BITS);

    localparam logic [LEN_W-1:0]   PORT_LIM  = LEN_W'(PORT_COUNT);
    localparam logic [LEN_W:0]     PORT_END  = (LEN_W + 1)'(PORT_COUNT);
    localparam logic [LEN_W-1:0]   WB_LEN    = LEN_W'(WORD_BITS);
    localparam logic [CNT_W-1:0]   WB_CNT    = CNT_W'(WORD_BITS);
    localparam logic [RCP_W-1:0]   RCP       = RCP_W'(RCP_VAL);
    localparam logic [DCNT_W-1:0]  DIV_STEPS = DCNT_W'(2);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Control state.
    logic [2:0]         state_reg, state_next;
    logic               lock_reg;
    logic               present_reg, present_next;
    logic [WADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [DCNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic               first_word_reg, first_word_next;
    logic               issued_last_reg, issued_last_next;
    logic               p_valid_reg, p_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Working values.
    logic                 cmd_reg, cmd_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic                 en_reg, en_next;
    logic [LEN_W-1:0]     lim_reg, lim_next;
    logic [WADDR_W-1:0]   q_reg, q_next;
    logic [WADDR_W-1:0]   word_reg, word_next;
    logic [LEN_W-1:0]     base_reg, base_next;
    logic [OFF_W-1:0]     lo_reg, lo_next;
    logic [WADDR_W-1:0]   p_addr_reg, p_addr_next;
    logic [OFF_W-1:0]     p_lo_reg, p_lo_next;
    logic [CNT_W-1:0]     p_top_reg, p_top_next;
    logic                 p_last_reg, p_last_next;
    logic                 p_first_reg, p_first_next;
    logic                 first_bit_reg, first_bit_next;
    status_t              status_reg, status_next;
    logic                 run_en_reg, run_en_next;
    logic [LEN_W-1:0]     run_len_reg, run_len_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Request fields.
    logic [START_W-1:0] in_start;
    logic [LEN_W-1:0]   in_len;
    logic               in_en;
    logic [LEN_W:0]     in_end;

    assign in_start = s_tdata[S_START_LSB +: START_W];
    assign in_len   = s_tdata[S_LEN_LSB +: LEN_W];
    assign in_en    = s_tdata[S_EN_BIT];
    assign in_end   = (LEN_W + 1)'(in_start) + (LEN_W + 1)'(in_len);

    // Memory ports.
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic               ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    iopbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    // Start word by reciprocal multiplication, then its first port.
    logic [PROD_W-1:0]  div_prod;
    logic [WADDR_W-1:0] div_q;
    logic [LEN_W-1:0]   q_base;

    assign div_prod = PROD_W'(start_reg) * PROD_W'(RCP);
    assign div_q    = WADDR_W'(div_prod >> DSH);
    assign q_base   = LEN_W'(q_reg) * WB_LEN;

    // Span of the word at the read address within the limit of this walk.
    logic [LEN_W-1:0] span;
    logic [CNT_W-1:0] top;
    logic             last;

    assign span = lim_reg - base_reg;
    assign top  = (span >= WB_LEN) ? WB_CNT : span[CNT_W-1:0];
    assign last = (span <= WB_LEN);

    // Bits of the returned word that lie inside the walked range.
    logic [WORD_BITS-1:0] range_mask;
    logic                 first_bit;
    logic [WORD_BITS-1:0] diff_bits;
    logic                 found;
    logic [OFF_W-1:0]     found_idx;
    logic [CNT_W-1:0]     add_cnt;
    logic [WORD_BITS-1:0] set_word;

    assign first_bit = p_first_reg ? ram_rdata[p_lo_reg] : first_bit_reg;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            range_mask[b] = (OFF_W'(b) >= p_lo_reg) && (CNT_W'(b) < p_top_reg);
        end
    end

    assign diff_bits = (ram_rdata ^ {WORD_BITS{first_bit}}) & range_mask;
    assign set_word  = en_reg ? (ram_rdata & ~range_mask) : (ram_rdata | range_mask);

    // Lowest bit that differs from the start bit.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (diff_bits[b])
            begin
                found     = 1'b1;
                found_idx = OFF_W'(b);
            end
        end
    end

    assign add_cnt = found ? (CNT_W'(found_idx) - CNT_W'(p_lo_reg))
                           : (p_top_reg - CNT_W'(p_lo_reg));

    // Write port: clearing pass or the modified word of a set walk.
    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_SCAN) && p_valid_reg && (cmd_reg == CMD_SET));
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : p_addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? {WORD_BITS{1'b1}} : set_word;
    assign ram_re    = (state_reg == S_SCAN) && !issued_last_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        present_next     = present_reg;
        clr_cnt_next     = clr_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        first_word_next  = first_word_reg;
        issued_last_next = issued_last_reg;
        p_valid_next     = 1'b0;
        m_tvalid_next    = m_tvalid_reg;
        cmd_next         = cmd_reg;
        start_next       = start_reg;
        en_next          = en_reg;
        lim_next         = lim_reg;
        q_next           = q_reg;
        word_next        = word_reg;
        base_next        = base_reg;
        lo_next          = lo_reg;
        p_addr_next      = p_addr_reg;
        p_lo_next        = p_lo_reg;
        p_top_next       = p_top_reg;
        p_last_next      = p_last_reg;
        p_first_next     = p_first_reg;
        first_bit_next   = first_bit_reg;
        status_next      = status_reg;
        run_en_next      = run_en_reg;
        run_len_next     = run_len_reg;
        m_tdata_next     = m_tdata_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = s_tuser;
                    start_next   = in_start;
                    en_next      = in_en;
                    status_next  = ST_OK;
                    run_en_next  = in_en;
                    run_len_next = '0;
                    div_cnt_next = DIV_STEPS;
                    state_next   = S_OUT;
                    if (s_tuser == CMD_SET)
                    begin
                        if (lock_reg)
                        begin
                            status_next = ST_NOT_PERMITTED;
                        end
                        else
                        begin
                            // The memory already holds all ones while absent.
                            present_next = 1'b1;
                            if (in_end > PORT_END)
                            begin
                                status_next = ST_INVALID;
                            end
                            else if (in_len != '0)
                            begin
                                lim_next   = in_end[LEN_W-1:0];
                                state_next = S_DIV;
                            end
                        end
                    end
                    else
                    begin
                        if (LEN_W'(in_start) >= PORT_LIM)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (present_reg)
                        begin
                            lim_next   = PORT_LIM;
                            state_next = S_DIV;
                        end
                    end
                end
            end

            S_DIV:
            begin
                // First the word is found, then its base port and bit offset.
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_STEPS)
                begin
                    q_next = div_q;
                end
                else
                begin
                    word_next        = q_reg;
                    base_next        = q_base;
                    lo_next          = start_reg[OFF_W-1:0] - q_base[OFF_W-1:0];
                    first_word_next  = 1'b1;
                    issued_last_next = 1'b0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read side: one word a cycle until the last word is out.
                if (!issued_last_reg)
                begin
                    p_valid_next    = 1'b1;
                    p_addr_next     = word_reg;
                    p_lo_next       = lo_reg;
                    p_top_next      = top;
                    p_last_next     = last;
                    p_first_next    = first_word_reg;
                    word_next       = word_reg + 1'b1;
                    base_next       = base_reg + WB_LEN;
                    lo_next         = '0;
                    first_word_next = 1'b0;
                    if (last)
                    begin
                        issued_last_next = 1'b1;
                    end
                end

                // Returned word: write back for a set, count the run for a get.
                if (p_valid_reg)
                begin
                    if (cmd_reg == CMD_GET)
                    begin
                        if (p_first_reg)
                        begin
                            first_bit_next = first_bit;
                            run_en_next    = !first_bit;
                        end
                        run_len_next = run_len_reg + LEN_W'(add_cnt);
                        if (found || p_last_reg)
                        begin
                            p_valid_next = 1'b0;
                            state_next   = S_OUT;
                        end
                    end
                    else if (p_last_reg)
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {(M_TDATA_W - M_USED_W)'(0), run_len_reg, run_en_reg,
                                     status_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            lock_reg        <= 1'b0;
            present_reg     <= 1'b0;
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            first_word_reg  <= 1'b0;
            issued_last_reg <= 1'b0;
            p_valid_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            present_reg     <= present_next;
            clr_cnt_reg     <= clr_cnt_next;
            div_cnt_reg     <= div_cnt_next;
            first_word_reg  <= first_word_next;
            issued_last_reg <= issued_last_next;
            p_valid_reg     <= p_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we)
            begin
                lock_reg <= cfg_wdata;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        start_reg     <= start_next;
        en_reg        <= en_next;
        lim_reg       <= lim_next;
        q_reg         <= q_next;
        word_reg      <= word_next;
        base_reg      <= base_next;
        lo_reg        <= lo_next;
        p_addr_reg    <= p_addr_next;
        p_lo_reg      <= p_lo_next;
        p_top_reg     <= p_top_next;
        p_last_reg    <= p_last_next;
        p_first_reg   <= p_first_next;
        first_bit_reg <= first_bit_next;
        status_reg    <= status_next;
        run_en_reg    <= run_en_next;
        run_len_reg   <= run_len_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule
